FILE: hdl/dsf_pkg.sv
// shared types, constants and the digit-to-segment table for the
// decimal seven-segment frame generator; no dependencies
package dsf_pkg;

  localparam int VALUE_W         = 28;
  localparam int COUNT_W         = 4;
  localparam int ADDR_W          = 4;
  localparam int SEG_W           = 8;
  localparam int DIGIT_COUNT_DEF = 8;

  localparam logic [SEG_W-1:0] SEG_MINUS = 8'h01;
  localparam logic [SEG_W-1:0] SEG_POINT = 8'h80;
  localparam logic [SEG_W-1:0] SEG_ONE   = 8'h30;

  // floor(x / 10) = (x * RECIP) >> SHIFT for any x below 2^32
  localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;
  localparam int          PROD_W      = VALUE_W + 32;
  localparam int          QUOT_W      = PROD_W - DIV10_SHIFT;

  typedef struct packed {
    logic               minus_one;
    logic               point;
    logic [COUNT_W-1:0] count;
  } frame_ctrl_t;

  function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
    logic [SEG_W-1:0] code;
    case (digit)
      4'd0:    code = 8'h7E;
      4'd1:    code = 8'h30;
      4'd2:    code = 8'h6D;
      4'd3:    code = 8'h79;
      4'd4:    code = 8'h33;
      4'd5:    code = 8'h5B;
      4'd6:    code = 8'h5F;
      4'd7:    code = 8'h70;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h7B;
      default: code = '0;
    endcase
    return code;
  endfunction

endpackage

FILE: hdl/dsf_digit_fmt.sv
// one digit step: splits the low decimal digit off the magnitude and
// forms the segment byte for the current position; uses dsf_pkg
module dsf_digit_fmt #(
  parameter int DIGIT_COUNT = dsf_pkg::DIGIT_COUNT_DEF
) (
  input  logic [dsf_pkg::VALUE_W-1:0]          mag_i,
  input  logic [$clog2(DIGIT_COUNT+1)-1:0]     pos_i,
  input  dsf_pkg::frame_ctrl_t                 ctrl_i,
  output logic [dsf_pkg::VALUE_W-1:0]          quot_o,
  output logic [dsf_pkg::SEG_W-1:0]            seg_o
);

  logic [dsf_pkg::PROD_W-1:0]  prod;
  logic [dsf_pkg::QUOT_W-1:0]  quot;
  logic [dsf_pkg::VALUE_W-1:0] quot_ext;
  logic [dsf_pkg::VALUE_W-1:0] rem_full;
  logic [3:0]                  digit;
  logic [dsf_pkg::COUNT_W-1:0] pos;
  logic [dsf_pkg::SEG_W-1:0]   code;

  assign prod     = dsf_pkg::PROD_W'(mag_i) * dsf_pkg::PROD_W'(dsf_pkg::DIV10_RECIP);
  assign quot     = prod[dsf_pkg::PROD_W-1:dsf_pkg::DIV10_SHIFT];
  assign quot_ext = dsf_pkg::VALUE_W'(quot);
  // remainder = x - 10*q, always below ten
  assign rem_full = mag_i - ((quot_ext << 3) + (quot_ext << 1));
  assign digit    = rem_full[3:0];
  assign quot_o   = quot_ext;

  assign pos  = dsf_pkg::COUNT_W'(pos_i);
  assign code = dsf_pkg::seg_code(digit);

  always_comb begin
    seg_o = '0;
    if (ctrl_i.minus_one) begin
      if (pos == 4'd1) begin
        seg_o = dsf_pkg::SEG_ONE;
      end else if (pos == 4'd2) begin
        seg_o = dsf_pkg::SEG_MINUS;
      end
    end else if (!ctrl_i.point) begin
      if (pos <= ctrl_i.count) begin
        seg_o = code;
      end
    end else if (pos <= 4'd2) begin
      seg_o = code;
    end else if (pos == 4'd3) begin
      // short counts still show a leading zero before the point
      if (ctrl_i.count <= 4'd2) begin
        seg_o = dsf_pkg::seg_code(4'd0) | dsf_pkg::SEG_POINT;
      end else begin
        seg_o = code | dsf_pkg::SEG_POINT;
      end
    end else if (pos <= ctrl_i.count) begin
      seg_o = code;
    end
  end

endmodule

FILE: hdl/decimal_seven_segment_frame_gen.sv
// Decimal seven-segment frame generator: turns a binary value into one
// no-decode display frame per digit position, low digit first.
// Depends on dsf_pkg and dsf_digit_fmt.
//
// Request channel: value_i, shown_digits_i and point_mode_i are taken at a
// rising edge where start is high and busy is low.
// Result channel: each frame (digit_address_o, segment_pattern_o,
// last_frame_o) is shown for one cycle with valid_o high; the receiver
// must take it, there is no back-pressure.
// Frame order: a request passes through the digit registers and then the
// result register before its first frame appears on the ports, then one
// frame per cycle, DIGIT_COUNT frames in all, the last with last_frame_o set.
// Sequencing: a shared divide-by-10 step (reciprocal multiply) peels one
// digit per cycle, so busy drops in the cycle of the last digit and the
// next request follows with no gap between frame runs.
// Reset: clears the sequencer and the result strobe; no frame is pending
// and busy is low after reset.
module decimal_seven_segment_frame_gen #(
  parameter int DIGIT_COUNT = dsf_pkg::DIGIT_COUNT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [dsf_pkg::VALUE_W-1:0] value_i,
  input  logic [dsf_pkg::COUNT_W-1:0]        shown_digits_i,
  input  logic                               point_mode_i,
  output logic                               valid_o,
  output logic [dsf_pkg::ADDR_W-1:0]         digit_address_o,
  output logic [dsf_pkg::SEG_W-1:0]          segment_pattern_o,
  output logic                               last_frame_o
);

  localparam int PosW = $clog2(DIGIT_COUNT + 1);
  localparam logic [PosW-1:0] PosLast = PosW'(DIGIT_COUNT);

  logic                        accept;
  logic [dsf_pkg::VALUE_W-1:0] raw;
  logic [dsf_pkg::VALUE_W-1:0] mag_in;
  dsf_pkg::frame_ctrl_t        ctrl_in;

  logic                        active_q;
  logic [PosW-1:0]             pos_q;
  logic [dsf_pkg::VALUE_W-1:0] mag_q;
  dsf_pkg::frame_ctrl_t        ctrl_q;

  logic [dsf_pkg::VALUE_W-1:0] quot;
  logic [dsf_pkg::SEG_W-1:0]   seg;

  logic                        valid_q;
  logic [dsf_pkg::ADDR_W-1:0]  addr_q;
  logic [dsf_pkg::SEG_W-1:0]   seg_q;
  logic                        last_q;

  assign busy   = active_q && (pos_q != PosLast);
  assign accept = start && !busy;

  assign raw    = value_i;
  assign mag_in = raw[dsf_pkg::VALUE_W-1] ? (~raw + dsf_pkg::VALUE_W'(1)) : raw;

  always_comb begin
    ctrl_in.minus_one = (raw == '1);
    ctrl_in.point     = point_mode_i;
    ctrl_in.count     = (shown_digits_i > dsf_pkg::COUNT_W'(DIGIT_COUNT))
                        ? dsf_pkg::COUNT_W'(DIGIT_COUNT) : shown_digits_i;
  end

  dsf_digit_fmt #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_digit_fmt (
    .mag_i  (mag_q),
    .pos_i  (pos_q),
    .ctrl_i (ctrl_q),
    .quot_o (quot),
    .seg_o  (seg)
  );

  // digit sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pos_q    <= '0;
    end else if (accept) begin
      active_q <= 1'b1;
      pos_q    <= PosW'(1);
    end else if (active_q) begin
      pos_q <= pos_q + PosW'(1);
      if (pos_q == PosLast) begin
        active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mag_q  <= mag_in;
      ctrl_q <= ctrl_in;
    end else if (active_q) begin
      mag_q <= quot;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (active_q) begin
      addr_q <= dsf_pkg::ADDR_W'(pos_q);
      seg_q  <= seg;
      last_q <= (pos_q == PosLast);
    end
  end

  assign valid_o           = valid_q;
  assign digit_address_o   = addr_q;
  assign segment_pattern_o = seg_q;
  assign last_frame_o      = last_q;

endmodule

FILE: hdl/dsf_checker.sv
// port-level checks for the decimal seven-segment frame generator,
// bound to the top level; depends on dsf_pkg
module dsf_checker #(
  parameter int DIGIT_COUNT = dsf_pkg::DIGIT_COUNT_DEF
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic                               valid_o,
  input logic [dsf_pkg::ADDR_W-1:0]         digit_address_o,
  input logic [dsf_pkg::SEG_W-1:0]          segment_pattern_o,
  input logic                               last_frame_o
);

  localparam logic [dsf_pkg::ADDR_W-1:0] AddrLast = dsf_pkg::ADDR_W'(DIGIT_COUNT);

  // an accepted request is followed by its first frame, at digit address one
  a_first_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 (valid_o && digit_address_o == 4'd1))
    else $error("first frame missing after request");

  // frames of one run come without gaps
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_frame_o) |=> valid_o)
    else $error("gap inside a frame run");

  a_addr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_frame_o) |=>
      (digit_address_o == $past(digit_address_o) + 4'd1))
    else $error("digit address did not step by one");

  a_last_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (last_frame_o == (digit_address_o == AddrLast)))
    else $error("last frame flag does not match the top position");

  // dp only ever lit on position three
  a_point_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && segment_pattern_o[7]) |-> (digit_address_o == 4'd3))
    else $error("decimal point on wrong position");

endmodule

bind decimal_seven_segment_frame_gen dsf_checker #(
  .DIGIT_COUNT(DIGIT_COUNT)
) u_dsf_checker (.*);

FILE: tb/sv/tb_decimal_seven_segment_frame_gen.sv
// testbench for decimal_seven_segment_frame_gen: directed and random requests,
// every frame checked against a local digit-splitting predictor
// depends on dsf_pkg and the frame generator rtl
module tb_decimal_seven_segment_frame_gen;

  localparam int DIGITS         = dsf_pkg::DIGIT_COUNT_DEF;
  localparam int RAND_REQUESTS  = 300;
  localparam int CALM_TAIL      = 60;
  localparam int WATCHDOG_LIMIT = 1000;

  // segment codes for digits 9 down to 0, digit d sits at bits [8d +: 8]
  localparam logic [79:0] DIGIT_SEGS =
    {8'h7B, 8'h7F, 8'h70, 8'h5F, 8'h5B, 8'h33, 8'h79, 8'h6D, 8'h30, 8'h7E};

  typedef struct packed {
    logic [dsf_pkg::ADDR_W-1:0] addr;
    logic [dsf_pkg::SEG_W-1:0]  seg;
    logic                       last;
  } frame_t;

  class frame_scoreboard;
    frame_t pending_frames[$];
    int     mismatches = 0;

    // split the request value into display frames, low position first
    function void add_request(logic [dsf_pkg::VALUE_W-1:0] value,
                              logic [dsf_pkg::COUNT_W-1:0] shown, logic point);
      logic [dsf_pkg::VALUE_W-1:0] mag;
      int unsigned                 rest;
      int unsigned                 digit;
      int unsigned                 lit;
      logic [dsf_pkg::SEG_W-1:0]   pat;
      frame_t                      f;
      lit = (int'(shown) > DIGITS) ? DIGITS : 32'(shown);
      mag = value;
      if (mag[dsf_pkg::VALUE_W-1]) mag = ~mag + 1'b1;
      rest = 32'(mag);
      for (int pos = 1; pos <= DIGITS; pos++) begin
        digit = rest % 10;
        rest  = rest / 10;
        pat   = '0;
        if (value == '1) begin
          // minus one is a fixed pattern in both modes
          if (pos == 1) pat = DIGIT_SEGS[8 +: 8];
          else if (pos == 2) pat = dsf_pkg::SEG_MINUS;
        end else if (!point) begin
          if (pos <= lit) pat = DIGIT_SEGS[digit*8 +: 8];
        end else if (pos <= 2) begin
          pat = DIGIT_SEGS[digit*8 +: 8];
        end else if (pos == 3) begin
          pat = ((lit <= 2) ? DIGIT_SEGS[7:0] : DIGIT_SEGS[digit*8 +: 8])
                | dsf_pkg::SEG_POINT;
        end else if (lit > 2 && pos <= lit) begin
          pat = DIGIT_SEGS[digit*8 +: 8];
        end
        f.addr = dsf_pkg::ADDR_W'(pos);
        f.seg  = pat;
        f.last = (pos == DIGITS);
        pending_frames.push_back(f);
      end
    endfunction

    function void check_frame(logic [dsf_pkg::ADDR_W-1:0] addr,
                              logic [dsf_pkg::SEG_W-1:0] seg, logic last);
      frame_t exp_f;
      if (pending_frames.size() == 0) begin
        $error("unexpected frame: digit_address %0d segment_pattern %h", addr, seg);
        mismatches++;
        return;
      end
      exp_f = pending_frames.pop_front();
      if (addr !== exp_f.addr) begin
        $error("digit_address: expected %0d, got %0d", exp_f.addr, addr);
        mismatches++;
      end
      if (seg !== exp_f.seg) begin
        $error("segment_pattern: expected %h, got %h", exp_f.seg, seg);
        mismatches++;
      end
      if (last !== exp_f.last) begin
        $error("last_frame: expected %b, got %b", exp_f.last, last);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_frames.size();
    endfunction
  endclass

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               start = 1'b0;
  logic                               busy;
  logic signed [dsf_pkg::VALUE_W-1:0] req_value = '0;
  logic [dsf_pkg::COUNT_W-1:0]        req_digits = '0;
  logic                               req_point = 1'b0;
  logic                               valid_o;
  logic [dsf_pkg::ADDR_W-1:0]         digit_address_o;
  logic [dsf_pkg::SEG_W-1:0]          segment_pattern_o;
  logic                               last_frame_o;
  int                                 idle_cycles = 0;
  frame_scoreboard                    frames;

  decimal_seven_segment_frame_gen #(.DIGIT_COUNT(DIGITS)) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .value_i           (req_value),
    .shown_digits_i    (req_digits),
    .point_mode_i      (req_point),
    .valid_o           (valid_o),
    .digit_address_o   (digit_address_o),
    .segment_pattern_o (segment_pattern_o),
    .last_frame_o      (last_frame_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // present one request and hold it until the block takes it,
  // then, if gap is above zero, drop start for the given number of cycles
  task automatic send_request(logic [dsf_pkg::VALUE_W-1:0] value,
                              logic [dsf_pkg::COUNT_W-1:0] shown, logic point, int gap);
    start      <= 1'b1;
    req_value  <= value;
    req_digits <= shown;
    req_point  <= point;
    do @(posedge clk_i); while (busy);
    frames.add_request(value, shown, point);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic int pick_gap(bit bursty);
    if (!bursty || $urandom_range(2, 0) != 0) return 0;
    return $urandom_range(16, 1);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && valid_o)
      frames.check_frame(digit_address_o, segment_pattern_o, last_frame_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [dsf_pkg::VALUE_W-1:0] value;
    logic [dsf_pkg::COUNT_W-1:0] shown;
    bit                          bursty;
    frames = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, both modes, minus one, saturation, short counts
    send_request(28'd0, 4'd8, 1'b0, 0);
    send_request(28'd0, 4'd0, 1'b0, 3);
    send_request(28'd99999999, 4'd8, 1'b0, 0);
    send_request(28'd99999999, 4'd8, 1'b1, 1);
    send_request('1, 4'd8, 1'b0, 0);
    send_request('1, 4'd0, 1'b1, 5);
    send_request(28'd12345678, 4'd15, 1'b0, 0);
    send_request(28'd12345678, 4'd9, 1'b1, 0);
    send_request(28'd1234, 4'd2, 1'b1, 2);
    send_request(28'd1234, 4'd0, 1'b1, 0);
    send_request(28'd5, 4'd3, 1'b1, 0);
    send_request(28'd987654, 4'd3, 1'b1, 7);
    send_request(28'd7, 4'd1, 1'b0, 0);
    send_request(28'h7FF_FFFF, 4'd8, 1'b0, 0);
    send_request(28'h800_0000, 4'd8, 1'b1, 0);
    send_request(-28'sd12345, 4'd5, 1'b0, 16);
    send_request(-28'sd2, 4'd8, 1'b1, 0);
    send_request(28'd3141592, 4'd6, 1'b1, 0);
    send_request(28'd90, 4'd4, 1'b0, 0);
    send_request(28'd4, 4'd1, 1'b1, 0);

    bursty = 1'b1;
    for (int i = 0; i < RAND_REQUESTS; i++) begin
      if (i % 25 == 0) bursty = ($urandom_range(3, 0) != 0);
      if (i >= RAND_REQUESTS - CALM_TAIL) bursty = 1'b0;
      case ($urandom_range(9, 0))
        0:       value = '1;
        1, 2:    value = dsf_pkg::VALUE_W'($urandom_range(999, 0));
        3, 4, 5: value = dsf_pkg::VALUE_W'($urandom_range(99999999, 0));
        default: value = dsf_pkg::VALUE_W'($urandom());
      endcase
      shown = ($urandom_range(6, 0) == 0) ? dsf_pkg::COUNT_W'($urandom_range(15, 9))
                                          : dsf_pkg::COUNT_W'($urandom_range(8, 0));
      send_request(value, shown, 1'($urandom_range(1, 0)), pick_gap(bursty));
    end
    start <= 1'b0;

    while (frames.pending() != 0) @(posedge clk_i);
    repeat (2 * DIGITS) @(posedge clk_i);
    if (frames.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
